### hw/rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants, codes and the line plan type of the midpoint line
// rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Coordinate width used inside the block and the fixed width on the ports
  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned PIX_W      = 6;
  // Scaled decision term and pixel counter widths
  localparam int unsigned DD_W       = COORD_BITS + 4;
  localparam int unsigned CNT_W      = COORD_BITS + 1;

  // Request opcodes
  typedef enum logic {
    OpMove = 1'b0,
    OpLine = 1'b1
  } op_e;

  // Test on the decision term that selects a minor-axis step
  typedef enum logic [1:0] {
    CondNone = 2'd0,
    CondGe   = 2'd1,
    CondGt   = 2'd2,
    CondLt   = 2'd3
  } cond_e;

  // Everything the walker needs to trace one line
  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic signed [DD_W-1:0] dd;
    logic signed [DD_W-1:0] inc_take;
    logic signed [DD_W-1:0] inc_keep;
    cond_e                  cond;
    logic                   major_y;
    logic                   major_neg;
    logic                   minor_neg;
    logic [CNT_W-1:0]       count;
  } plan_t;

endpackage

### hw/rtl/mlr_cmd_if.sv
// ----------------------------------------------------------------------------
// mlr_cmd_if / mlr_pix_if
// Valid/ready channels for move/line requests and for plotted pixels.
// ----------------------------------------------------------------------------
interface mlr_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [mlr_pkg::PIX_W-1:0]         pt_x;
  logic [mlr_pkg::PIX_W-1:0]         pt_y;

  modport source (output valid, output op, output pt_x, output pt_y, input ready);
  modport sink   (input valid, input op, input pt_x, input pt_y, output ready);
endinterface

interface mlr_pix_if;
  logic                              valid;
  logic                              ready;
  logic [mlr_pkg::PIX_W-1:0]         pix_x;
  logic [mlr_pkg::PIX_W-1:0]         pix_y;
  logic                              last;

  modport source (output valid, output pix_x, output pix_y, output last, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input last, output ready);
endinterface

### hw/rtl/mlr_plan.sv
// ----------------------------------------------------------------------------
// mlr_plan
// Classify a line into vertical, shallow or steep and derive the start
// point, step directions, decision term and increments for the walker.
// ----------------------------------------------------------------------------
module mlr_plan (
  input  logic [mlr_pkg::COORD_BITS-1:0] cur_x_i,
  input  logic [mlr_pkg::COORD_BITS-1:0] cur_y_i,
  input  logic [mlr_pkg::COORD_BITS-1:0] tgt_x_i,
  input  logic [mlr_pkg::COORD_BITS-1:0] tgt_y_i,
  output mlr_pkg::plan_t                 plan_o
);

  localparam int unsigned CW = mlr_pkg::COORD_BITS;
  localparam int unsigned DW = mlr_pkg::DD_W;

  logic signed [CW:0]   dx, dy, ndx, ndy;
  logic [CW:0]          adx_w, ady_w;
  logic [CW-1:0]        adx, ady;
  logic                 dx_neg, dy_neg, dx_zero, dy_zero, same, b_gt_a;
  logic signed [DW-1:0] a1, b1, a2, b2;

  // Signed spans and their magnitudes
  assign dx      = signed'({1'b0, tgt_x_i}) - signed'({1'b0, cur_x_i});
  assign dy      = signed'({1'b0, tgt_y_i}) - signed'({1'b0, cur_y_i});
  assign ndx     = -dx;
  assign ndy     = -dy;
  assign dx_neg  = dx[CW];
  assign dy_neg  = dy[CW];
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign adx_w   = dx_neg ? ndx : dx;
  assign ady_w   = dy_neg ? ndy : dy;
  assign adx     = adx_w[CW-1:0];
  assign ady     = ady_w[CW-1:0];
  assign same    = (!dx_neg && !dx_zero) == (!dy_neg && !dy_zero);
  assign b_gt_a  = (ady > adx);

  assign a1 = signed'({{(DW-CW){1'b0}}, adx});
  assign b1 = signed'({{(DW-CW){1'b0}}, ady});
  assign a2 = a1 <<< 1;
  assign b2 = b1 <<< 1;

  // Pick class, start end and step rules
  always_comb begin
    plan_o           = '0;
    plan_o.x         = cur_x_i;
    plan_o.y         = cur_y_i;
    plan_o.inc_take  = a2 - b2;
    plan_o.cond      = mlr_pkg::CondNone;
    if (dx_zero) begin
      // vertical: both ends, upward from the lower one
      plan_o.y         = dy_neg ? tgt_y_i : cur_y_i;
      plan_o.major_y   = 1'b1;
      plan_o.count     = mlr_pkg::CNT_W'({1'b0, ady}) + mlr_pkg::CNT_W'(1);
    end else if (!dy_zero && b_gt_a) begin
      // steep: walk y, x always moves up; decision term kept in upward form
      plan_o.major_y   = 1'b1;
      plan_o.dd        = a2 - b1;
      plan_o.inc_keep  = a2;
      plan_o.count     = {1'b0, ady};
      if (same) begin
        plan_o.cond      = mlr_pkg::CondGe;
        plan_o.x         = dy_neg ? tgt_x_i : cur_x_i;
        plan_o.y         = dy_neg ? tgt_y_i : cur_y_i;
      end else begin
        plan_o.cond      = mlr_pkg::CondGt;
        plan_o.major_neg = 1'b1;
        plan_o.x         = dy_neg ? cur_x_i : tgt_x_i;
        plan_o.y         = dy_neg ? cur_y_i : tgt_y_i;
      end
    end else begin
      // shallow: walk x upward; the falling case steps y downward
      plan_o.dd        = a1 - b2;
      plan_o.inc_keep  = -b2;
      plan_o.cond      = mlr_pkg::CondLt;
      plan_o.minor_neg = !dy_zero && !same;
      plan_o.count     = {1'b0, adx};
      plan_o.x         = dx_neg ? tgt_x_i : cur_x_i;
      plan_o.y         = dx_neg ? tgt_y_i : cur_y_i;
    end
  end

endmodule

### hw/rtl/mlr_walk.sv
// ----------------------------------------------------------------------------
// mlr_walk
// Iterative midpoint stepper: one shared adder updates the decision term
// and the current pixel moves one step along the major axis per advance.
// ----------------------------------------------------------------------------
module mlr_walk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  mlr_pkg::plan_t                 plan_i,
  input  logic                           adv_i,
  output logic [mlr_pkg::COORD_BITS-1:0] x_o,
  output logic [mlr_pkg::COORD_BITS-1:0] y_o,
  output logic                           last_o,
  output logic                           busy_o
);

  localparam int unsigned CW = mlr_pkg::COORD_BITS;
  localparam int unsigned DW = mlr_pkg::DD_W;

  logic [CW-1:0]              x_q, x_d, y_q, y_d;
  logic signed [DW-1:0]       dd_q, dd_d, inc_take_q, inc_keep_q;
  mlr_pkg::cond_e             cond_q;
  logic                       major_y_q, major_neg_q, minor_neg_q;
  logic [mlr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       take;
  logic [CW-1:0]              maj_step, min_step;

  // Evaluate the midpoint test
  always_comb begin
    case (cond_q)
      mlr_pkg::CondGe: take = !dd_q[DW-1];
      mlr_pkg::CondGt: take = !dd_q[DW-1] && (dd_q != '0);
      mlr_pkg::CondLt: take = dd_q[DW-1];
      default:         take = 1'b0;
    endcase
  end

  // Major and minor step sizes for advancing the pixel
  assign maj_step = major_neg_q ? {CW{1'b1}} : CW'(1);
  assign min_step = take ? (minor_neg_q ? {CW{1'b1}} : CW'(1)) : '0;

  always_comb begin
    dd_d  = dd_q + (take ? inc_take_q : inc_keep_q);
    cnt_d = cnt_q - mlr_pkg::CNT_W'(1);
    if (major_y_q) begin
      y_d = y_q + maj_step;
      x_d = x_q + min_step;
    end else begin
      x_d = x_q + maj_step;
      y_d = y_q + min_step;
    end
  end

  // Hold the remaining pixel count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= plan_i.count;
    end else if (adv_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Load the plan, then step on each advance
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q         <= plan_i.x;
      y_q         <= plan_i.y;
      dd_q        <= plan_i.dd;
      inc_take_q  <= plan_i.inc_take;
      inc_keep_q  <= plan_i.inc_keep;
      cond_q      <= plan_i.cond;
      major_y_q   <= plan_i.major_y;
      major_neg_q <= plan_i.major_neg;
      minor_neg_q <= plan_i.minor_neg;
    end else if (adv_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      dd_q <= dd_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign last_o = (cnt_q == mlr_pkg::CNT_W'(1));
  assign busy_o = (cnt_q != '0);

endmodule

### hw/rtl/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer with a current-point register. Move requests set
// the current point; line requests emit one pixel per cycle, unless the output stalls, with a last mark.
// ----------------------------------------------------------------------------
// Pipeline: the first pixel of an accepted line request goes through the walker
//   registers and then into the output register, when the output register is free.
// Throughput: one pixel per cycle from the shared stepper unless the output stalls;
//   a line holds the request port until its last pixel leaves; a move does not.
// Reset: asynchronous, active low; current point returns to (0, 0), no
//   pixel pending.
module midpoint_line_rasterizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  mlr_cmd_if.sink         cmd_i,
  mlr_pix_if.source       pix_o
);

  localparam int unsigned CW = mlr_pkg::COORD_BITS;
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                  state_q, state_d;
  logic [CW-1:0]         cur_x_q, cur_y_q;
  logic [CW-1:0]         tgt_x, tgt_y;
  logic                  accept, load, adv;
  mlr_pkg::plan_t        plan;
  logic [CW-1:0]         walk_x, walk_y;
  logic                  walk_last, walk_busy;
  logic                  ov_q;
  logic [CW-1:0]         ox_q, oy_q;
  logic                  olast_q;

  assign tgt_x  = cmd_i.pt_x[CW-1:0];
  assign tgt_y  = cmd_i.pt_y[CW-1:0];
  assign cmd_i.ready = (state_q == StIdle);
  assign accept = cmd_i.valid && cmd_i.ready;
  assign load   = accept && (mlr_pkg::op_e'(cmd_i.op) == mlr_pkg::OpLine);
  assign adv    = (state_q == StRun) && (!ov_q || pix_o.ready);

  mlr_plan u_plan (
    .cur_x_i (cur_x_q),
    .cur_y_i (cur_y_q),
    .tgt_x_i (tgt_x),
    .tgt_y_i (tgt_y),
    .plan_o  (plan)
  );

  mlr_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .plan_i (plan),
    .adv_i  (adv),
    .x_o    (walk_x),
    .y_o    (walk_y),
    .last_o (walk_last),
    .busy_o (walk_busy)
  );

  // Sequence: idle until a line request, run until the last pixel leaves
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (load) state_d = StRun;
      StRun:  if (adv && walk_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Hold state, current point and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_x_q <= '0;
      cur_y_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cur_x_q <= tgt_x;
        cur_y_q <= tgt_y;
      end
      if (adv) begin
        ov_q <= 1'b1;
      end else if (pix_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Capture the pixel into the output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q    <= walk_x;
      oy_q    <= walk_y;
      olast_q <= walk_last;
    end
  end

  assign pix_o.valid = ov_q;
  assign pix_o.pix_x = mlr_pkg::PIX_W'(ox_q);
  assign pix_o.pix_y = mlr_pkg::PIX_W'(oy_q);
  assign pix_o.last  = olast_q;

  // Running always has pixels left to emit
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> walk_busy)
    else $error("rasterizer running with no pixels left");

  // The last pixel returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && walk_last) |=> (state_q == StIdle))
    else $error("sequencer did not finish after last pixel");

  // A move request produces no pixel
  a_move_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !load && !ov_q) |=> !pix_o.valid)
    else $error("move request produced a pixel");

endmodule
